// File: rtl/blcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blcp_pkg;

  // pattern mode codes, same encoding as the new_mode field
  typedef logic [3:0] mode_t;

  localparam mode_t MODE_OFF       = 4'd0;
  localparam mode_t MODE_GREEN     = 4'd1;
  localparam mode_t MODE_RED       = 4'd2;
  localparam mode_t MODE_AMBER     = 4'd3;
  localparam mode_t MODE_AMBERFAST = 4'd4;
  localparam mode_t MODE_REDFAST   = 4'd5;
  localparam mode_t MODE_REDSLOW   = 4'd6;
  localparam mode_t MODE_GREEN3    = 4'd7;
  localparam mode_t MODE_RED3      = 4'd8;
  localparam mode_t MODE_RED5      = 4'd9;

  // item kinds carried on tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // register map, word index taken from paddr[2]
  localparam logic REG_BLANK_GAP = 1'b0;
  localparam logic REG_SLOW_HOLD = 1'b1;

  localparam logic [6:0] BLANK_GAP_RESET = 7'd12;
  localparam logic [6:0] SLOW_HOLD_RESET = 7'd3;

  // flash pattern end counts
  localparam logic [7:0] FLASH3_LIMIT = 8'd6;
  localparam logic [7:0] FLASH5_LIMIT = 8'd10;

  localparam logic [7:0] PHASE_BIT = 8'h80;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] phase;
    logic [6:0] blank;
    logic       red;
    logic       green;
  } blcp_state_t;

  typedef struct packed {
    logic       cmd;
    mode_t      new_mode;
    logic       thermal_stepdown;
  } blcp_item_t;

endpackage

`default_nettype wire

// File: rtl/blcp_step.sv
`timescale 1ns / 1ps
`default_nettype none

module blcp_step (
  input  blcp_pkg::blcp_item_t  item,
  input  blcp_pkg::blcp_state_t cur,
  input  logic [6:0]            blank_gap,
  input  logic [6:0]            slow_blink_hold,
  output blcp_pkg::blcp_state_t nxt
);
  import blcp_pkg::*;

  logic       skip;
  logic [6:0] cnt;
  logic [6:0] limit;
  logic [7:0] flash_cnt;
  logic [7:0] flash_limit;
  logic [7:0] toggled;

  always_comb begin
    skip        = 1'b0;
    nxt         = cur;
    cnt         = cur.phase[6:0];
    limit       = (cur.mode == MODE_REDSLOW) ? slow_blink_hold : 7'd0;
    flash_cnt   = {1'b0, cur.phase[6:0]};
    flash_limit = (cur.mode == MODE_RED5) ? FLASH5_LIMIT : FLASH3_LIMIT;
    toggled     = cur.phase[7] ? 8'd0 : PHASE_BIT;

    if (item.cmd == CMD_LOAD) begin
      nxt.mode = item.new_mode;
    end else begin
      // thermal blanking
      if (item.thermal_stepdown) begin
        if (cur.blank < blank_gap) begin
          nxt.blank = cur.blank + 7'd1;
        end else begin
          nxt.blank = 7'd0;
          nxt.red   = 1'b0;
          nxt.green = 1'b0;
          skip      = 1'b1;
        end
      end else begin
        nxt.blank = 7'd0;
      end

      if (!skip) begin
        case (cur.mode)
          MODE_OFF: begin
            nxt.red   = 1'b0;
            nxt.green = 1'b0;
            nxt.phase = 8'd0;
          end
          MODE_GREEN: begin
            nxt.red   = 1'b0;
            nxt.green = 1'b1;
          end
          MODE_RED: begin
            nxt.red   = 1'b1;
            nxt.green = 1'b0;
          end
          MODE_AMBER: begin
            nxt.red   = 1'b1;
            nxt.green = 1'b1;
          end
          MODE_AMBERFAST: begin
            nxt.phase = toggled;
            nxt.red   = toggled[7];
            nxt.green = toggled[7];
          end
          MODE_REDFAST, MODE_REDSLOW: begin
            nxt.green = 1'b0;
            if (cnt < limit) begin
              nxt.phase = {cur.phase[7], cnt + 7'd1};
            end else begin
              nxt.phase = toggled;
            end
            nxt.red = nxt.phase[7];
          end
          MODE_GREEN3, MODE_RED3, MODE_RED5: begin
            if (flash_cnt > flash_limit) begin
              // pattern finished, leds hold
              nxt.phase = flash_cnt;
              nxt.mode  = MODE_OFF;
            end else begin
              nxt.phase = flash_cnt + 8'd1;
              if (flash_cnt[0]) begin
                if (cur.mode == MODE_GREEN3) begin
                  nxt.green = 1'b1;
                end else begin
                  nxt.red = 1'b1;
                end
              end else begin
                nxt.red   = 1'b0;
                nxt.green = 1'b0;
              end
            end
          end
          default: begin
            // undefined modes hold everything
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/bicolor_led_pattern_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// a request passes through the input register and then the result register
// throughput: one request per cycle, tick or mode load, with no bubbles while the result side is ready
// backpressure on the master side stalls the result register, and the input stage once it is full;
// the input stage still takes a request while a result waits if the input register is empty
// reset (rst, synchronous, active high): mode off, leds off, timer and blank
// counter cleared, blank_gap = 12, slow_blink_hold = 3
module bicolor_led_pattern_controller (
  input  logic       clk,
  input  logic       rst,
  // request stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] new_mode, [4] thermal_stepdown, [7:5] zero
  input  logic       s_axis_tuser,   // [0] cmd
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] red_on, [1] green_on, [5:2] mode_now, [7:6] zero
  // configuration port
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  import blcp_pkg::*;

  // configuration registers
  logic [6:0] blank_gap;
  logic [6:0] slow_blink_hold;

  // input stage
  logic       in_valid;
  blcp_item_t in_item;

  // pattern state and result stage
  blcp_state_t state;
  blcp_state_t state_next;
  logic        out_valid;

  logic out_free;
  logic in_move;

  // result register frees when empty or being taken
  assign out_free      = !out_valid || m_axis_tready;
  assign in_move       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // apb: always ready, register index is paddr[2]
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_gap       <= BLANK_GAP_RESET;
      slow_blink_hold <= SLOW_HOLD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_BLANK_GAP: blank_gap       <= pwdata[6:0];
        REG_SLOW_HOLD: slow_blink_hold <= pwdata[6:0];
        default:       blank_gap       <= blank_gap;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BLANK_GAP: prdata = {25'd0, blank_gap};
      REG_SLOW_HOLD: prdata = {25'd0, slow_blink_hold};
      default:       prdata = 32'd0;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.cmd              <= s_axis_tuser;
      in_item.new_mode         <= s_axis_tdata[3:0];
      in_item.thermal_stepdown <= s_axis_tdata[4];
    end
  end

  // next pattern state for the request in the input register
  blcp_step u_step (
    .item            (in_item),
    .cur             (state),
    .blank_gap       (blank_gap),
    .slow_blink_hold (slow_blink_hold),
    .nxt             (state_next)
  );

  // state advances as each request moves into the result register;
  // the result fields are read straight from the updated state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= in_valid;
      end
      if (in_move) begin
        state <= state_next;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, state.mode, state.green, state.red};

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import blcp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS  = 40;

  // one led result as the block reports it
  typedef struct packed {
    logic  red;
    logic  green;
    mode_t mode;
  } led_out_t;

  logic        clk;
  logic        rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [3:0] new_mode, [4] thermal_stepdown, [7:5] zero
  logic        s_axis_tuser = 1'b0;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [7:0]  m_axis_tdata;          // [0] red_on, [1] green_on, [5:2] mode_now, [7:6] zero

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  bicolor_led_pattern_controller u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // requests waiting to go out, and led results still owed by the block
  blcp_item_t pending_req_q[$];
  led_out_t   led_want_q[$];

  // shadow of the block state and its registers
  mode_t      led_mode  = MODE_OFF;
  logic [7:0] tmr       = 8'd0;
  logic [6:0] blank_cnt = 7'd0;
  logic       red_lvl   = 1'b0;
  logic       grn_lvl   = 1'b0;
  logic [6:0] gap_cfg   = BLANK_GAP_RESET;
  logic [6:0] hold_cfg  = SLOW_HOLD_RESET;

  int  err_cnt = 0;
  int  cycles = 0;
  bit  idle_on = 1'b1;     // random gaps on both sides
  int  hold_asks = 0;      // bumped to ask the receiver for one long hold-off
  bit  req_taken = 1'b0;   // request accepted at the last rising edge

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_cnt < MAX_PRINTS)
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // advance the shadow state by one request and queue the led result it gives
  task automatic step_led_pattern(input blcp_item_t it);
    logic [7:0] cnt;
    logic [7:0] lim;
    bit         blanked;
    led_out_t   res;
    blanked = 1'b0;
    if (it.cmd == CMD_LOAD) begin
      // mode load leaves timer, counter and leds alone
      led_mode = it.new_mode;
    end else begin
      if (it.thermal_stepdown) begin
        if (blank_cnt < gap_cfg) begin
          blank_cnt = blank_cnt + 7'd1;
        end else begin
          // blanking flash: both off and the mode waits a tick
          blank_cnt = 7'd0;
          red_lvl = 1'b0;
          grn_lvl = 1'b0;
          blanked = 1'b1;
        end
      end else begin
        blank_cnt = 7'd0;
      end
      if (!blanked) begin
        case (led_mode)
          MODE_OFF: begin
            red_lvl = 1'b0;
            grn_lvl = 1'b0;
            tmr = 8'd0;
          end
          MODE_GREEN: begin
            red_lvl = 1'b0;
            grn_lvl = 1'b1;
          end
          MODE_RED: begin
            red_lvl = 1'b1;
            grn_lvl = 1'b0;
          end
          MODE_AMBER: begin
            red_lvl = 1'b1;
            grn_lvl = 1'b1;
          end
          MODE_AMBERFAST: begin
            tmr = tmr[7] ? 8'd0 : PHASE_BIT;
            red_lvl = tmr[7];
            grn_lvl = tmr[7];
          end
          MODE_REDFAST, MODE_REDSLOW: begin
            grn_lvl = 1'b0;
            cnt = {1'b0, tmr[6:0]};
            lim = (led_mode == MODE_REDSLOW) ? {1'b0, hold_cfg} : 8'd0;
            // hold the half period, then flip phase and restart the count
            if (cnt < lim) tmr = {tmr[7], cnt[6:0] + 7'd1};
            else tmr = tmr[7] ? 8'd0 : PHASE_BIT;
            red_lvl = tmr[7];
          end
          MODE_GREEN3, MODE_RED3, MODE_RED5: begin
            tmr = {1'b0, tmr[6:0]};
            lim = (led_mode == MODE_RED5) ? FLASH5_LIMIT : FLASH3_LIMIT;
            if (tmr > lim) begin
              // one-shot done, leds hold this tick
              led_mode = MODE_OFF;
            end else begin
              cnt = tmr;
              tmr = tmr + 8'd1;
              if (cnt[0]) begin
                if (led_mode == MODE_GREEN3) grn_lvl = 1'b1;
                else red_lvl = 1'b1;
              end else begin
                red_lvl = 1'b0;
                grn_lvl = 1'b0;
              end
            end
          end
          default: ;  // undefined modes hold everything
        endcase
      end
    end
    res.red = red_lvl;
    res.green = grn_lvl;
    res.mode = led_mode;
    led_want_q.push_back(res);
  endtask

  // request side: accept at the rising edge, predict right away
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      req_taken = 1'b1;
      step_led_pattern(pending_req_q.pop_front());
    end
  end

  // request driver, changes at the falling edge and keeps a request up until taken
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !req_taken) begin
      // still waiting for the block
    end else if (send_gap > 0) begin
      send_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (pending_req_q.size() == 0) begin
      s_axis_tvalid <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      send_gap = $urandom_range(1, 15) - 1;
      s_axis_tvalid <= 1'b0;
    end else begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {3'b000, pending_req_q[0].thermal_stepdown, pending_req_q[0].new_mode};
      s_axis_tuser  <= pending_req_q[0].cmd;
    end
  end

  // result side ready, with short stalls and the occasional long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = $urandom_range(150, 300);
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result check against the oldest expectation, field by field
  always @(posedge clk) begin
    led_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (led_want_q.size() == 0) begin
        report_mismatch("result with nothing owed, tdata", m_axis_tdata, 0);
      end else begin
        want = led_want_q.pop_front();
        if (m_axis_tdata[0] !== want.red)
          report_mismatch("red_on", m_axis_tdata[0], want.red);
        if (m_axis_tdata[1] !== want.green)
          report_mismatch("green_on", m_axis_tdata[1], want.green);
        if (m_axis_tdata[5:2] !== want.mode)
          report_mismatch("mode_now", m_axis_tdata[5:2], want.mode);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // register write over the config port, setup then access
  task automatic cfg_write(input logic idx, input logic [6:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {25'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_BLANK_GAP) gap_cfg = val;
    else hold_cfg = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_load(input mode_t m);
    blcp_item_t it;
    it.cmd = CMD_LOAD;
    it.new_mode = m;
    it.thermal_stepdown = 1'($urandom_range(0, 1));
    pending_req_q.push_back(it);
  endtask

  task automatic push_tick(input logic hot);
    blcp_item_t it;
    it.cmd = CMD_TICK;
    it.new_mode = mode_t'($urandom_range(0, 15));  // don't care on ticks
    it.thermal_stepdown = hot;
    pending_req_q.push_back(it);
  endtask

  // random mode loads, most followed by a run of ticks; long runs reach
  // the slow blink turnover and the blanking flash at wide settings
  task automatic queue_pattern_runs(input int n_items);
    int    made;
    int    run_len;
    int    heat;
    mode_t m;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 15) == 0) m = mode_t'($urandom_range(10, 15));
      else m = mode_t'($urandom_range(0, 9));
      push_load(m);
      made++;
      if ($urandom_range(0, 9) == 0) continue;  // back-to-back loads
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 280)
                                            : $urandom_range(1, 24);
      heat = $urandom_range(0, 2);
      repeat (run_len) begin
        if (heat == 0) push_tick(1'b0);
        else if (heat == 1) push_tick(1'b1);
        else push_tick(1'($urandom_range(0, 1)));
        made++;
      end
    end
  endtask

  // sender waits here until every owed result is back
  task automatic drain;
    while (pending_req_q.size() != 0 || led_want_q.size() != 0 || s_axis_tvalid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every mode at reset settings, undefined modes, step-down on and off
    push_tick(1'b0);
    push_load(MODE_GREEN);      push_tick(1'b0);
    push_load(MODE_RED);        push_tick(1'b1);
    push_load(MODE_AMBER);      push_tick(1'b0);
    push_load(MODE_AMBERFAST);  push_tick(1'b0);  push_tick(1'b1);
    push_load(MODE_REDFAST);    push_tick(1'b0);  push_tick(1'b0);
    push_load(MODE_REDSLOW);    push_tick(1'b0);  push_tick(1'b0);
    push_load(MODE_GREEN3);     push_tick(1'b0);  push_tick(1'b0);
    push_load(MODE_RED3);       push_tick(1'b0);
    push_load(MODE_RED5);       push_tick(1'b0);
    push_load(mode_t'(4'd12));  push_tick(1'b1);
    push_load(mode_t'(4'd15));  push_tick(1'b0);
    push_load(MODE_OFF);        push_tick(1'b0);
    queue_pattern_runs(300);
    drain();

    // narrowest settings, blanking on every hot tick; long receiver hold-off here
    cfg_write(REG_BLANK_GAP, 7'd0);
    cfg_write(REG_SLOW_HOLD, 7'd0);
    hold_asks++;
    queue_pattern_runs(350);
    drain();

    // wide settings, one below the register maximum
    cfg_write(REG_BLANK_GAP, 7'd126);
    cfg_write(REG_SLOW_HOLD, 7'd126);
    queue_pattern_runs(350);
    drain();

    cfg_write(REG_SLOW_HOLD, 7'($urandom_range(0, 126)));
    cfg_write(REG_BLANK_GAP, 7'($urandom_range(0, 126)));
    hold_asks++;
    queue_pattern_runs(350);
    drain();

    // last stretch at full rate on both sides
    idle_on = 1'b0;
    cfg_write(REG_BLANK_GAP, 7'd1);
    cfg_write(REG_SLOW_HOLD, 7'd5);
    queue_pattern_runs(400);
    drain();

    repeat (8) @(posedge clk);
    if (err_cnt == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/blcp_pkg.sv
rtl/blcp_step.sv
rtl/bicolor_led_pattern_controller.sv
sim/tb.sv
